[sv/assert_macros.svh]
// Assertion macros shared by the event queue modules.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/toeq_pkg.sv]
// Shared types and constants for the time ordered event queue.
// No dependencies.
package toeq_pkg;

	localparam int CAPACITY      = 16;
	localparam int COUNT_W       = $clog2(CAPACITY + 1);
	localparam int ENTRY_COUNT_W = 5;
	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] etime;
		logic [3:0]  kind;
		logic [15:0] data_one;
		logic [15:0] data_two;
	} ev_t;

	typedef struct packed {
		op_t op;
		ev_t ev;
	} item_t;

	// handshake between the front queue and the back end
	typedef struct packed {
		logic valid;
		logic pop;
	} link_t;

	typedef struct packed {
		status_t              status;
		ev_t                  ev;
		logic                 is_empty;
		logic [COUNT_W-1:0]   count;
	} rsp_t;

endpackage

[sv/toeq_if.sv]
// Request and result channel interfaces for the event queue.
// Depends on nothing but the field widths of the request and result.
interface toeq_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] event_time;
	logic [3:0]  event_kind;
	logic [15:0] data_one;
	logic [15:0] data_two;

	modport source (output valid, req_type, event_time, event_kind, data_one, data_two,
		input ready);
	modport sink (input valid, req_type, event_time, event_kind, data_one, data_two,
		output ready);
endinterface

interface toeq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_time;
	logic [3:0]  out_kind;
	logic [15:0] out_data_one;
	logic [15:0] out_data_two;
	logic        is_empty;
	logic [4:0]  entry_count;

	modport source (output valid, status, out_time, out_kind, out_data_one, out_data_two,
		is_empty, entry_count, input ready);
	modport sink (input valid, status, out_time, out_kind, out_data_one, out_data_two,
		is_empty, entry_count, output ready);
endinterface

[sv/toeq_front.sv]
// Front end: takes requests, classifies them and holds them in a short queue.
// Depends on toeq_pkg, toeq_if and assert_macros.svh.
`include "assert_macros.svh"

module toeq_front import toeq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	toeq_req_if.sink     req,
	input  link_t        link_in,
	output link_t        link_out,
	output item_t        head
);

	item_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pop;
	item_t                 item_in;

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
		ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign req.ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign push      = req.valid && req.ready;
	assign pop       = link_in.pop;

	always_comb begin
		item_in.op          = req.req_type ? OP_REMOVE : OP_INSERT;
		item_in.ev.etime    = req.event_time;
		item_in.ev.kind     = req.event_kind;
		item_in.ev.data_one = req.data_one;
		item_in.ev.data_two = req.data_two;
	end

	always_comb begin
		link_out.valid = (cnt_q != '0);
		link_out.pop   = 1'b0;
		head           = fifo_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_pop_when_empty, pop && (cnt_q == '0), "back end popped an empty queue")
	`ASSERT_CLK(a_ptr_track, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q),
		"queue pointers disagree with fill count")

endmodule

[sv/toeq_back.sv]
// Back end: sorted cell array of events and the result register.
// Depends on toeq_pkg, toeq_if and assert_macros.svh.
`include "assert_macros.svh"

module toeq_back import toeq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  link_t        link_in,
	output link_t        link_out,
	input  item_t        head,
	toeq_rsp_if.source   rsp
);

	ev_t                cells_q [CAPACITY];
	ev_t                ins_cells [CAPACITY];
	ev_t                rem_cells [CAPACITY];
	ev_t                cells_d [CAPACITY];
	logic [CAPACITY-1:0] le;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	rsp_t               res_d;
	rsp_t               out_q;
	logic               out_valid_q;
	logic               pop;

	assign pop = link_in.valid && (!out_valid_q || rsp.ready);

	always_comb begin
		link_out.valid = 1'b0;
		link_out.pop   = pop;
	end

	// each cell compares its own time with the incoming one; the array is
	// sorted, so the ones in le form a prefix and mark where the event goes
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			le[i] = (COUNT_W'(i) < count_q) && (cells_q[i].etime <= head.ev.etime);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (le[i]) begin
				ins_cells[i] = cells_q[i];
			end else if (i == 0) begin
				ins_cells[i] = head.ev;
			end else if (le[i-1]) begin
				ins_cells[i] = head.ev;
			end else begin
				ins_cells[i] = cells_q[i-1];
			end
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == CAPACITY - 1) begin
				rem_cells[i] = cells_q[i];
			end else begin
				rem_cells[i] = cells_q[i+1];
			end
		end
	end

	always_comb begin
		cells_d      = cells_q;
		count_d      = count_q;
		res_d.status = ST_OK;
		res_d.ev     = '0;
		unique case (head.op)
			OP_INSERT: begin
				if (count_q >= COUNT_W'(CAPACITY)) begin
					res_d.status = ST_FULL;
				end else begin
					cells_d = ins_cells;
					count_d = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					res_d.status = ST_EMPTY;
				end else begin
					res_d.ev = cells_q[0];
					cells_d  = rem_cells;
					count_d  = count_q - 1'b1;
				end
			end
			default: begin
				res_d.status = ST_OK;
			end
		endcase
		res_d.count    = count_d;
		res_d.is_empty = (count_d == '0);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cells_q <= cells_d;
			out_q   <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.out_time     = out_q.ev.etime;
	assign rsp.out_kind     = out_q.ev.kind;
	assign rsp.out_data_one = out_q.ev.data_one;
	assign rsp.out_data_two = out_q.ev.data_two;
	assign rsp.is_empty     = out_q.is_empty;
	assign rsp.entry_count  = ENTRY_COUNT_W'(out_q.count);

	`ASSERT_CLK(a_count_cap, count_q <= COUNT_W'(CAPACITY), "entry count above capacity")
	`ASSERT_CLK(a_head_sorted, (count_q >= COUNT_W'(2)) |-> (cells_q[0].etime <= cells_q[1].etime),
		"first two cells out of time order")
	`ASSERT_CLK(a_full_count, (out_valid_q && (out_q.status == ST_FULL)) |->
		(out_q.count == COUNT_W'(CAPACITY)), "full status with queue not full")

endmodule

[sv/time_ordered_event_queue.sv]
// Time ordered event queue, top level.
// Depends on toeq_pkg, toeq_if, toeq_front and toeq_back.
//
// Channels: req carries insert (req_type 0) and remove (req_type 1) requests;
// rsp returns one result per request, in request order, with status, the
// removed event (zero unless a remove succeeded), is_empty and entry_count.
// Up to 16 events are held sorted by time; equal times leave in arrival order.
// A request passes through the request queue, then into the result register.
// Throughput: one request per cycle sustained while rsp is ready; every
// request is done in a single pass over the cell array, each cell comparing
// its own time against the incoming one and shifting locally.
// A two-entry request queue sits between the front and the cell array, so
// req stays ready while a result waits on rsp, until that queue is full.
// Reset: asynchronous, clears the entry count and all handshake state; the
// queue is empty and ready right after reset is released, with no clearing pass.
// A stalled rsp holds its result stable; the cell array stops and the
// request queue fills, then req.ready drops until results are taken.
module time_ordered_event_queue import toeq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	toeq_req_if.sink     req,
	toeq_rsp_if.source   rsp
);

	link_t front_link;
	link_t back_link;
	item_t head;

	toeq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.link_in  (back_link),
		.link_out (front_link),
		.head     (head)
	);

	toeq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.link_in  (front_link),
		.link_out (back_link),
		.head     (head),
		.rsp      (rsp)
	);

endmodule
